FILE: rtl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the glob matcher: pattern geometry, request
// codes, wildcard bytes and the per-cell match terms.
// ----------------------------------------------------------------------------
package wgm_pkg;

    // Number of pattern positions (one cell each).
    localparam int PATTERN_MAX = 64;

    // Fixed field widths of the request and register.
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int PAT_IDX_W  = 6;
    localparam int CFG_LEN_W  = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Select width for the match row (PATTERN_MAX + 1 bits).
    localparam int ROW_SEL_W = $clog2(PATTERN_MAX + 1);

    // Register word index carried by paddr[2].
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    // Wildcard bytes.
    localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'h3F;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TEXT  = 2'd2
    } t_op;

    // Per-cell terms fed to the star span unit.
    typedef struct packed {
        logic gen;   // position matches regardless of its left neighbor
        logic prop;  // pattern byte is a star: pass the left result on
    } t_cell_term;

endpackage

FILE: rtl/wgm_cell.sv
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds its pattern byte and its match-row bit, and
// forms the generate/propagate terms for the next row.
// ----------------------------------------------------------------------------
module wgm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [wgm_pkg::CHAR_W-1:0] i_char,
    input  logic                      i_row_left,
    input  logic                      i_row_upd,
    input  logic                      i_row_next,
    output wgm_pkg::t_cell_term       o_term,
    output logic                      o_row
);
    import wgm_pkg::*;

    logic [CHAR_W-1:0] r_pat;
    logic              r_row;
    logic              w_star;
    logic              w_hit;

    // Pattern byte: no reset, unwritten entries are never read by contract.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pat <= i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 1'b0;
        end else if (i_row_upd) begin
            r_row <= i_row_next;
        end
    end

    assign w_star = (r_pat == STAR_BYTE);
    assign w_hit  = (r_pat == ANY_BYTE) || (r_pat == i_char);

    // A star keeps its own bit alive; a literal or '?' takes the left bit.
    assign o_term.gen  = w_star ? r_row : (w_hit & i_row_left);
    assign o_term.prop = w_star;
    assign o_row       = r_row;

endmodule

FILE: rtl/wgm_span.sv
// ----------------------------------------------------------------------------
// wgm_span
// Star span resolver: runs the generate/propagate terms of all cells through
// one carry chain, so a match spreads right across any run of stars.
// ----------------------------------------------------------------------------
module wgm_span (
    input  wgm_pkg::t_cell_term [wgm_pkg::PATTERN_MAX-1:0] i_term,
    input  logic                                           i_cin,
    output logic [wgm_pkg::PATTERN_MAX:1]                  o_row
);
    import wgm_pkg::*;

    logic [PATTERN_MAX-1:0] w_a;
    logic [PATTERN_MAX-1:0] w_b;
    logic [PATTERN_MAX:0]   w_sum;
    logic [PATTERN_MAX:0]   w_carry;

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            w_a[k] = i_term[k].gen | i_term[k].prop;
            w_b[k] = i_term[k].gen;
        end
    end

    // Carry into bit k+1 is the next-row bit of position k+1.
    assign w_sum   = {1'b0, w_a} + {1'b0, w_b} + {{PATTERN_MAX{1'b0}}, i_cin};
    assign w_carry = w_sum ^ {1'b0, w_a} ^ {1'b0, w_b};
    assign o_row   = w_carry[PATTERN_MAX:1];

endmodule

FILE: rtl/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Streams text bytes against a stored glob pattern ('*' any run, '?' any
// single byte) and reports per request whether the text so far matches.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  request   in         i_valid / o_ready   i_operation, i_char_value,
//                                           i_pattern_index
//  result    out        o_valid / i_ready   o_matched
//  config    in         APB psel/penable    paddr, pwdata, prdata
//
//  A new request is taken every cycle unless the result channel stalls.
//  The match row updates at the accepting edge and the result sits in one
//  output register the cycle after; the carry chain of the span unit sets
//  the clock period.
//  o_ready drops only while a result waits and i_ready is low.
//  Reset (synchronous, active low) clears the row to bit zero set, the
//  length to zero and the result valid; pattern bytes are not cleared.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [wgm_pkg::OP_W-1:0]       i_operation,
    input  logic [wgm_pkg::CHAR_W-1:0]     i_char_value,
    input  logic [wgm_pkg::PAT_IDX_W-1:0]  i_pattern_index,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_matched,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wgm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wgm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wgm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import wgm_pkg::*;

    // registers
    logic [CFG_LEN_W-1:0] r_len;
    logic [CFG_LEN_W-1:0] n_len;
    logic                 r_row0;
    logic                 n_row0;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_matched;
    logic                 n_matched;

    // request decode
    t_op                  w_op;
    logic                 w_acc;
    logic                 w_is_load;
    logic                 w_is_start;
    logic                 w_is_text;
    logic                 w_row_upd;

    // row datapath
    t_cell_term [PATTERN_MAX-1:0] w_term_raw;
    t_cell_term [PATTERN_MAX-1:0] w_term;
    logic [PATTERN_MAX:0]         w_row_cur;
    logic [PATTERN_MAX:0]         w_row_nxt;
    logic [PATTERN_MAX:1]         w_span;
    logic [ROW_SEL_W-1:0]         w_sel;
    logic                         w_cfg_wr;

    // ------------------------------------------------------------------
    // Handshake: accept whenever the output register is free or draining.
    // ------------------------------------------------------------------
    assign o_ready = !r_out_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_op    = t_op'(i_operation);

    always_comb begin
        w_is_load  = 1'b0;
        w_is_start = 1'b0;
        w_is_text  = 1'b0;
        case (w_op)
            OP_LOAD:  w_is_load  = 1'b1;
            OP_START: w_is_start = 1'b1;
            OP_TEXT:  w_is_text  = 1'b1;
            default: begin
                // unused code: no effect, result reads zero
            end
        endcase
    end

    assign w_row_upd = w_acc && (w_is_start || w_is_text);

    // ------------------------------------------------------------------
    // Cell row. Cell k holds pattern byte k and row bit k+1; row bit 0
    // lives here. Each cell sees its left neighbor's row bit.
    // ------------------------------------------------------------------
    assign w_row_cur[0] = r_row0;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        wgm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (w_acc && w_is_load &&
                         (i_pattern_index == PAT_IDX_W'(k))),
            .i_char     (i_char_value),
            .i_row_left (w_row_cur[k]),
            .i_row_upd  (w_row_upd),
            .i_row_next (w_row_nxt[k+1]),
            .o_term     (w_term_raw[k]),
            .o_row      (w_row_cur[k+1])
        );
    end

    // A start seeds the row: drop every generate term and carry in a one,
    // so only the leading star run lights up.
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            w_term[k].gen  = w_term_raw[k].gen & !w_is_start;
            w_term[k].prop = w_term_raw[k].prop;
        end
    end

    wgm_span u_span (
        .i_term (w_term),
        .i_cin  (w_is_start),
        .o_row  (w_span)
    );

    assign w_row_nxt = {w_span, w_is_start};

    // Saturate the length to the row size, then pick the reported bit.
    assign w_sel = (int'(r_len) > PATTERN_MAX) ? ROW_SEL_W'(PATTERN_MAX)
                                               : ROW_SEL_W'(r_len);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_len = r_len;
        if (w_cfg_wr && (paddr[2] == REG_PATTERN_LENGTH)) begin
            n_len = pwdata[CFG_LEN_W-1:0];
        end
    end

    always_comb begin
        n_row0 = r_row0;
        if (w_row_upd) begin
            n_row0 = w_is_start;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_matched   = r_matched;
        if (w_acc) begin
            n_out_valid = 1'b1;
            n_matched   = (w_is_start || w_is_text) && w_row_nxt[w_sel];
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_row0      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_row0      <= n_row0;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload: held while the consumer stalls.
    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_matched;

    // ------------------------------------------------------------------
    // Configuration read-back
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PATTERN_LENGTH)
                  ? {{(APB_DATA_W-CFG_LEN_W){1'b0}}, r_len}
                  : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_valid)
        else $error("accepted request produced no result");

    a_load_reports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_load) |=> !o_matched)
        else $error("load request reported a match");

    a_empty_pattern_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_start && (r_len == '0)) |=> o_matched)
        else $error("empty text failed to match empty pattern");

    a_text_clears_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_text) |=> !r_row0)
        else $error("row bit zero survived a text byte");

endmodule

FILE: test/wildcard_glob_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_tb
// Self-checking bench for the glob matcher. It loads the pattern, sets the
// length over APB and streams texts through the request channel. Each result
// is checked against a cycle-free glob predictor. Both handshake sides idle
// at random, and one long result stall backs up the request channel.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_tb;
    import wgm_pkg::*;

    localparam int          IDLE_PCT        = 28;    // idle odds per cycle, in percent
    localparam int          RANDOM_REQUESTS = 370;   // random requests before wrap-up
    localparam int          STALL_LIMIT     = 1000;  // cycles with no handshake at all
    localparam int          SETTLE_CYCLES   = 2;     // pipeline slack before a register write
    localparam int          TAIL_CYCLES     = 4;     // slack after the last result
    localparam int          LONG_STALL      = 80;    // long result back-pressure stretch
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;  // code with no function

    // Directed rows: either a request or a length write (value in the char field).
    typedef enum logic {ROW_REQ, ROW_LEN} t_row_kind;

    // How a directed request's result is known.
    localparam logic [1:0] CHECK_ZERO = 2'd0;
    localparam logic [1:0] CHECK_ONE  = 2'd1;
    localparam logic [1:0] CHECK_CALC = 2'd2;

    typedef struct packed {
        t_row_kind             kind;
        logic [OP_W-1:0]       op;
        logic [CHAR_W-1:0]     ch;
        logic [PAT_IDX_W-1:0]  idx;
        logic [1:0]            want;
    } t_plan_row;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   i_valid         = 1'b0;
    logic                   o_ready;
    logic [OP_W-1:0]        i_operation     = '0;
    logic [CHAR_W-1:0]      i_char_value    = '0;
    logic [PAT_IDX_W-1:0]   i_pattern_index = '0;
    logic                   o_valid;
    logic                   i_ready         = 1'b0;
    logic                   o_matched;
    logic                   psel            = 1'b0;
    logic                   penable         = 1'b0;
    logic                   pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr           = '0;
    logic [APB_DATA_W-1:0]  pwdata          = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    wildcard_glob_matcher u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_char_value    (i_char_value),
        .i_pattern_index (i_pattern_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_matched       (o_matched),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Glob predictor state: pattern bytes, match row over all positions,
    // and the length register as last written.
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0]      pattern_mem [PATTERN_MAX];
    logic [PATTERN_MAX:0]   row_bits;
    logic [CFG_LEN_W-1:0]   length_reg;

    logic                   pending_matches [$];   // expected o_matched, oldest first
    int                     mismatch_count  = 0;
    int                     result_count    = 0;
    int                     random_requests = 0;
    int                     stuck_cycles    = 0;
    bit                     steady          = 1'b0; // suppress idling on both sides
    int                     stall_ask       = 0;    // receiver picks this up as a hold-off

    t_plan_row directed_plan [26] = '{
        // text before any start walks the reset row; nothing matches length 0
        '{ROW_REQ, OP_TEXT,   8'h61, 6'd0,  CHECK_ZERO},
        // empty text against empty pattern
        '{ROW_REQ, OP_START,  8'h00, 6'd0,  CHECK_ONE},
        '{ROW_REQ, OP_UNUSED, 8'hFF, 6'd63, CHECK_ZERO},
        '{ROW_REQ, OP_LOAD,   STAR_BYTE, 6'd0, CHECK_ZERO},
        '{ROW_REQ, OP_LOAD,   ANY_BYTE,  6'd1, CHECK_ZERO},
        '{ROW_REQ, OP_LOAD,   8'hFF, 6'd2,  CHECK_ZERO},
        '{ROW_REQ, OP_LOAD,   8'h00, 6'd63, CHECK_ZERO},
        '{ROW_LEN, OP_LOAD,   8'h03, 6'd0,  CHECK_CALC},
        '{ROW_REQ, OP_START,  8'h00, 6'd0,  CHECK_CALC},
        '{ROW_REQ, OP_TEXT,   8'h00, 6'd21, CHECK_CALC},
        '{ROW_REQ, OP_TEXT,   8'hFF, 6'd42, CHECK_CALC},
        '{ROW_REQ, OP_TEXT,   8'hFF, 6'd0,  CHECK_CALC},
        // saturating length, written mid text
        '{ROW_LEN, OP_LOAD,   8'h7F, 6'd0,  CHECK_CALC},
        '{ROW_REQ, OP_TEXT,   8'h7A, 6'd63, CHECK_CALC},
        '{ROW_LEN, OP_LOAD,   8'h00, 6'd0,  CHECK_CALC},
        '{ROW_REQ, OP_TEXT,   8'h61, 6'd0,  CHECK_ZERO},
        '{ROW_REQ, OP_START,  8'h61, 6'd0,  CHECK_ONE},
        '{ROW_LEN, OP_LOAD,   8'h40, 6'd0,  CHECK_CALC},
        // pattern edited mid text
        '{ROW_REQ, OP_LOAD,   STAR_BYTE, 6'd2, CHECK_ZERO},
        '{ROW_REQ, OP_TEXT,   STAR_BYTE, 6'd0, CHECK_CALC},
        '{ROW_REQ, OP_START,  8'h00, 6'd0,  CHECK_CALC},
        '{ROW_LEN, OP_LOAD,   8'h01, 6'd0,  CHECK_CALC},
        // a lone leading star matches the empty text
        '{ROW_REQ, OP_START,  8'h00, 6'd0,  CHECK_ONE},
        '{ROW_REQ, OP_TEXT,   ANY_BYTE, 6'd0, CHECK_CALC},
        '{ROW_LEN, OP_LOAD,   8'h41, 6'd0,  CHECK_CALC},
        '{ROW_REQ, OP_TEXT,   8'h00, 6'd0,  CHECK_CALC}
    };

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Apply one request to the predictor state and return the match bit it
    // should report.
    function automatic logic glob_predict(input logic [OP_W-1:0] op,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [PAT_IDX_W-1:0] idx);
        logic [PATTERN_MAX:0] next_row;
        logic                 star_run;
        int                   used;
        used = (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
        case (op)
            OP_LOAD: begin
                pattern_mem[idx] = ch;
                return 1'b0;
            end
            OP_START: begin
                // seed position zero and every position behind leading stars
                star_run    = 1'b1;
                row_bits[0] = 1'b1;
                for (int j = 1; j <= PATTERN_MAX; j++) begin
                    star_run    = star_run && (pattern_mem[j-1] == STAR_BYTE);
                    row_bits[j] = star_run;
                end
                return row_bits[used];
            end
            OP_TEXT: begin
                next_row[0] = 1'b0;
                for (int j = 1; j <= PATTERN_MAX; j++) begin
                    if (pattern_mem[j-1] == STAR_BYTE) begin
                        next_row[j] = next_row[j-1] | row_bits[j];
                    end else if (pattern_mem[j-1] == ANY_BYTE || pattern_mem[j-1] == ch) begin
                        next_row[j] = row_bits[j-1];
                    end else begin
                        next_row[j] = 1'b0;
                    end
                end
                row_bits = next_row;
                return row_bits[used];
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offer one request, hold it until taken, then log what it must report.
    // Valid is left high on return so back-to-back requests never glitch it.
    task automatic push_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [PAT_IDX_W-1:0] idx, input logic [1:0] want);
        logic hit;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_char_value    <= ch;
        i_pattern_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        hit = glob_predict(op, ch, idx);
        pending_matches = {pending_matches, ((want == CHECK_CALC) ? hit : want[0])};
        if (op != OP_UNUSED) random_requests++;
    endtask

    // Drop valid and hold until every request has produced its result.
    task automatic drain_requests();
        i_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write pattern_length over APB with the block idle, then read it back.
    task automatic set_length(input logic [APB_DATA_W-1:0] word);
        drain_requests();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PATTERN_LENGTH, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register taken at this edge; go straight into a read setup
        length_reg = word[CFG_LEN_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== APB_DATA_W'(length_reg)) begin
            report_mismatch($sformatf("pattern_length reads %0h, wrote %0h",
                                      prdata, length_reg));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_text_byte();
        if ($urandom_range(99) < 80) return CHAR_W'(8'h61 + $urandom_range(2));
        return CHAR_W'($urandom_range(255));
    endfunction

    // One glob case: load a pattern, set its length, then stream a text that
    // mostly matches it, with stray requests mixed in.
    task automatic run_glob_case(input bit long_form);
        logic [CHAR_W-1:0] pat [$];
        logic [CHAR_W-1:0] txt [$];
        int                plen;
        int                pick;
        logic [CFG_LEN_W-1:0] len_val;
        plen = long_form ? $urandom_range(PATTERN_MAX, 20) : $urandom_range(8);
        for (int i = 0; i < plen; i++) begin
            pick = $urandom_range(99);
            if (pick < 25) pat = {pat, STAR_BYTE};
            else if (pick < 40) pat = {pat, ANY_BYTE};
            else pat = {pat, CHAR_W'(8'h61 + $urandom_range(2))};
            push_request(OP_LOAD, pat[i], PAT_IDX_W'(i), CHECK_CALC);
        end
        len_val = ($urandom_range(99) < 8) ? CFG_LEN_W'($urandom_range(127, 65))
                                           : CFG_LEN_W'(plen);
        set_length({25'($urandom()), len_val});

        // build a text that the pattern accepts, then maybe spoil it
        foreach (pat[i]) begin
            if (pat[i] == STAR_BYTE) begin
                repeat ($urandom_range(3)) txt = {txt, pick_text_byte()};
            end else if (pat[i] == ANY_BYTE) begin
                txt = {txt, pick_text_byte()};
            end else begin
                txt = {txt, pat[i]};
            end
        end
        pick = $urandom_range(99);
        if (pick < 25 && txt.size() != 0) txt[$urandom_range(txt.size() - 1)] = pick_text_byte();
        else if (pick < 35) txt = {txt, pick_text_byte()};
        else if (pick < 40 && txt.size() != 0) void'(txt.pop_back());

        push_request(OP_START, CHAR_W'($urandom()), PAT_IDX_W'($urandom()), CHECK_CALC);
        foreach (txt[i]) begin
            if ($urandom_range(99) < 8) begin
                case ($urandom_range(3))
                    0: push_request(OP_UNUSED, CHAR_W'($urandom()), PAT_IDX_W'($urandom()),
                                    CHECK_CALC);
                    1: push_request(OP_LOAD, CHAR_W'($urandom()), PAT_IDX_W'($urandom()),
                                    CHECK_CALC);
                    2: push_request(OP_START, CHAR_W'($urandom()), PAT_IDX_W'($urandom()),
                                    CHECK_CALC);
                    default: push_request(OP_TEXT, CHAR_W'($urandom()),
                                          PAT_IDX_W'($urandom()), CHECK_CALC);
                endcase
            end
            push_request(OP_TEXT, txt[i], PAT_IDX_W'($urandom()), CHECK_CALC);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: drop i_ready at random, or for a long stretch on request.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_ask != 0) begin
                stall_left = stall_ask;
                stall_ask  = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        logic want_hit;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_matches.size() == 0) begin
                report_mismatch($sformatf("result %0d with no request pending", result_count));
            end else begin
                want_hit = pending_matches.pop_front();
                if (o_matched !== want_hit) begin
                    report_mismatch($sformatf("result %0d: matched %0b, predicted %0b",
                                              result_count, o_matched, want_hit));
                end
            end
            result_count++;
        end
    end

    // Watchdog: end the run when no handshake moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int        case_no;
        t_plan_row step;
        row_bits   = '0;
        row_bits[0] = 1'b1;
        length_reg = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every pattern position first: each start or text request reads
        // the whole store, and unwritten cells are undefined.
        for (int i = 0; i < PATTERN_MAX; i++) begin
            push_request(OP_LOAD, 8'h7A, PAT_IDX_W'(i), CHECK_ZERO);
        end

        foreach (directed_plan[i]) begin
            step = directed_plan[i];
            if (step.kind == ROW_LEN) begin
                set_length({25'($urandom()), step.ch[CFG_LEN_W-1:0]});
            end else begin
                push_request(step.op, step.ch, step.idx, step.want);
            end
        end

        // Random cases. Case 2 runs with a long result stall while a long
        // pattern keeps the request side busy; a later run of cases has no
        // idling at all. Every case drains before its length write.
        random_requests = 0;
        case_no         = 0;
        while (random_requests < RANDOM_REQUESTS) begin
            if (case_no == 2) begin
                steady    = 1'b1;
                stall_ask = LONG_STALL;
            end else begin
                steady = (case_no >= 8 && case_no < 16);
            end
            run_glob_case(case_no == 2 || case_no % 12 == 5);
            case_no++;
        end

        i_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_matches.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/wgm_pkg.sv
rtl/wgm_cell.sv
rtl/wgm_span.sv
rtl/wildcard_glob_matcher.sv
test/wildcard_glob_matcher_tb.sv
